// File: hw/rtl/stps_pkg.sv
// stps_pkg: shared types and constants of the sine taylor partial sum core
// used by stps_round_mul and sine_taylor_partial_sum_core; no dependencies
package stps_pkg;

    localparam int TERM_COUNT_BITS = 4;
    localparam logic [TERM_COUNT_BITS-1:0] TERM_COUNT_RESET = 4'd10;
    localparam int RECIP_BITS = 32;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_TERM,
        ST_RECIP,
        ST_DONE
    } stps_state_t;

    typedef enum logic [1:0] {
        MUL_SQUARE,
        MUL_TERM,
        MUL_RECIP
    } mul_op_t;

endpackage

// File: hw/rtl/stps_round_mul.sv
// stps_round_mul: shared multiplier with round-half-up and right shift
// depends on stps_pkg for the operation codes and reciprocal width
module stps_round_mul
    import stps_pkg::*;
#(
    parameter int A_W       = 20,
    parameter int B_W       = 32,
    parameter int FRAC_BITS = 16
)
(
    input  mul_op_t        op,
    input  logic [A_W-1:0] a,
    input  logic [B_W-1:0] b,
    output logic [A_W-1:0] result
);

    localparam int P_W = A_W + B_W;
    localparam logic [P_W:0] HALF_F = (P_W+1)'(1) << (FRAC_BITS - 1);
    localparam logic [P_W:0] HALF_R = (P_W+1)'(1) << (RECIP_BITS - 1);

    logic [P_W:0] prod;
    logic [P_W:0] shifted;

    assign prod = (P_W+1)'(a) * (P_W+1)'(b);

    always_comb
    begin
        case (op) inside
            MUL_SQUARE, MUL_TERM:
            begin
                shifted = (prod + HALF_F) >> FRAC_BITS;
            end
            MUL_RECIP:
            begin
                shifted = (prod + HALF_R) >> RECIP_BITS;
            end
            default:
            begin
                shifted = '0;
            end
        endcase
    end

    assign result = shifted[A_W-1:0];

endmodule

// File: hw/rtl/sine_taylor_partial_sum_core.sv
// sine_taylor_partial_sum_core: top level, sequencer, term registers and accumulator
// depends on stps_pkg and stps_round_mul
//
// Takes one angle (signed, FRAC_BITS fraction bits) per request when start is high and
// busy is low, and returns the saturated partial Taylor sum of sin over n+1 terms on
// series_sum with a one-cycle done strobe, where n = min(term_count, MAX_TERMS-1). A new
// request is taken only once busy is low again, after done: one shared multiplier forms
// the square of the angle once and then two rounded products per term. The receiver
// cannot stall: series_sum holds the result from the cycle done is high until the next
// request is taken. term_count is written through cfg_valid/cfg_ready, which is
// always ready; write it only while busy is low.
module sine_taylor_partial_sum_core
    import stps_pkg::*;
#(
    parameter int MAX_TERMS = 16,
    parameter int FRAC_BITS = 16
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic signed [FRAC_BITS+1:0] angle,
    output logic                       busy,
    output logic                       done,
    output logic signed [FRAC_BITS+1:0] series_sum,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [TERM_COUNT_BITS-1:0] term_count
);

    localparam int VAL_W    = FRAC_BITS + 2;
    localparam int A_W      = FRAC_BITS + 4;
    localparam int B_W      = (FRAC_BITS + 3 > RECIP_BITS) ? FRAC_BITS + 3 : RECIP_BITS;
    localparam int KW       = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
    localparam int SUM_W    = VAL_W + $clog2(MAX_TERMS) + 1;
    localparam int LAST_MAX = MAX_TERMS - 1;
    localparam logic signed [SUM_W-1:0] SAT_TOP = signed'((SUM_W'(1) << (VAL_W - 1)) - SUM_W'(1));
    localparam logic signed [SUM_W-1:0] SAT_BOT = -signed'(SUM_W'(1) << (VAL_W - 1));

    stps_state_t state_reg;
    stps_state_t state_next;

    logic [TERM_COUNT_BITS-1:0] term_count_reg;
    logic [KW-1:0]              k_reg;
    logic [KW-1:0]              last_reg;
    logic                       neg_reg;
    logic [VAL_W-1:0]           t_reg;
    logic [VAL_W:0]             x2_reg;
    logic [A_W-1:0]             p_reg;
    logic signed [SUM_W-1:0]    sum_reg;

    logic [RECIP_BITS-1:0] recip_tab [2**KW];

    mul_op_t        mul_op;
    logic [A_W-1:0] mul_a;
    logic [B_W-1:0] mul_b;
    logic [A_W-1:0] mul_result;

    logic [VAL_W-1:0]        angle_mag;
    logic [KW-1:0]           last_sel;
    logic signed [SUM_W-1:0] term_ext;
    logic                    term_neg;

    // reciprocals of (2k+2)(2k+3), rounded to nearest
    for (genvar g = 0; g < 2**KW; g++)
    begin : g_recip
        localparam longint unsigned DEN = longint'((2*g + 2) * (2*g + 3));
        localparam logic [RECIP_BITS-1:0] RECIP =
            RECIP_BITS'(((64'd1 << RECIP_BITS) + DEN / 2) / DEN);
        assign recip_tab[g] = RECIP;
    end

    stps_round_mul #(
        .A_W       (A_W),
        .B_W       (B_W),
        .FRAC_BITS (FRAC_BITS)
    ) u_round_mul (
        .op     (mul_op),
        .a      (mul_a),
        .b      (mul_b),
        .result (mul_result)
    );

    assign angle_mag = angle[VAL_W-1] ? VAL_W'(-angle) : VAL_W'(angle);
    assign last_sel  = (int'(term_count_reg) > LAST_MAX) ? KW'(LAST_MAX) : KW'(term_count_reg);
    assign term_ext  = signed'(SUM_W'(t_reg));
    assign term_neg  = neg_reg ^ k_reg[0];

    // operand selection for the shared multiplier
    always_comb
    begin
        unique case (state_reg)
            ST_TERM:
            begin
                mul_op = MUL_TERM;
                mul_a  = A_W'(t_reg);
                mul_b  = B_W'(x2_reg);
            end
            ST_RECIP:
            begin
                mul_op = MUL_RECIP;
                mul_a  = p_reg;
                mul_b  = B_W'(recip_tab[k_reg]);
            end
            default:
            begin
                mul_op = MUL_SQUARE;
                mul_a  = A_W'(t_reg);
                mul_b  = B_W'(t_reg);
            end
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_SQUARE;
                end
            end
            ST_SQUARE:
            begin
                state_next = ST_TERM;
            end
            ST_TERM:
            begin
                state_next = (k_reg == last_reg) ? ST_DONE : ST_RECIP;
            end
            ST_RECIP:
            begin
                state_next = ST_TERM;
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        busy      = (state_reg != ST_IDLE);
        done      = (state_reg == ST_DONE);
        cfg_ready = 1'b1;
        if (sum_reg > SAT_TOP)
        begin
            series_sum = SAT_TOP[VAL_W-1:0];
        end
        else if (sum_reg < SAT_BOT)
        begin
            series_sum = SAT_BOT[VAL_W-1:0];
        end
        else
        begin
            series_sum = sum_reg[VAL_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            term_count_reg <= TERM_COUNT_RESET;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                term_count_reg <= term_count;
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    t_reg    <= angle_mag;
                    neg_reg  <= angle[VAL_W-1];
                    last_reg <= last_sel;
                    k_reg    <= '0;
                    sum_reg  <= '0;
                end
            end
            ST_SQUARE:
            begin
                x2_reg <= mul_result[VAL_W:0];
            end
            ST_TERM:
            begin
                sum_reg <= term_neg ? (sum_reg - term_ext) : (sum_reg + term_ext);
                p_reg   <= mul_result;
            end
            ST_RECIP:
            begin
                t_reg <= mul_result[VAL_W-1:0];
                k_reg <= k_reg + KW'(1);
            end
            default:
            begin
            end
        endcase
    end

endmodule
